// File: sv/i2cmbe_pkg.sv
`timescale 1ns / 1ps

package i2cmbe_pkg;

   // command codes carried by the func field
   localparam logic [2:0] OP_IDLE  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;
   localparam logic [2:0] OP_ACK   = 3'd5;

   // register map
   localparam int          CSR_ADDR_W      = 3;
   localparam int          CSR_DATA_W      = 32;
   localparam logic [0:0]  REG_PHASE_TICKS = 1'b0;

   localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;

   // phases per command
   localparam logic [4:0] PHASES_WRITE = 5'd16;
   localparam logic [4:0] PHASES_READ  = 5'd17;
   localparam logic [4:0] PHASES_OTHER = 5'd3;

   function automatic logic [4:0] phase_total(input logic [2:0] op);
      priority if (op == OP_WRITE) begin
         return PHASES_WRITE;
      end else if (op == OP_READ) begin
         return PHASES_READ;
      end else begin
         return PHASES_OTHER;
      end
   endfunction

endpackage

// File: sv/i2c_master_bit_engine_top.sv
`timescale 1ns / 1ps

// open-drain i2c master bit engine, one request per base tick. every accepted
// request advances the line sequencer by one tick and yields exactly one
// response carrying scl/sda drive, busy, a done pulse, the last received byte
// and the last sampled acknowledge. the sequencer state is updated at the
// accepting edge and the response lands in an output register in the same
// edge, so a new request is taken every cycle while the response side keeps
// up (the output register alone can hold a request back). while
// idle a request with func start/stop/write/read/ack launches that command;
// commands arriving while busy are ignored. phase_ticks (csr offset 0) sets
// ticks per bus phase, zero acts as one; write it only while no command runs.
module i2c_master_bit_engine_top (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_func,
   input  logic [7:0]                          req_tx_byte,
   input  logic                                req_ack_level,
   input  logic                                req_sda_in,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_scl_out,
   output logic                                rsp_sda_out,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic [7:0]                          rsp_rx_byte,
   output logic                                rsp_ack_sampled,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [i2cmbe_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [i2cmbe_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [i2cmbe_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                pready
);

   // ---------------------------------------------------------------------
   // configuration register
   // ---------------------------------------------------------------------
   logic [15:0] phase_ticks_ff;
   logic        csr_sel_phase;

   // word index lives above the byte offset
   assign csr_sel_phase = (paddr[i2cmbe_pkg::CSR_ADDR_W-1] == i2cmbe_pkg::REG_PHASE_TICKS);
   assign pready        = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= i2cmbe_pkg::PHASE_TICKS_RESET;
      end else if (psel && penable && pwrite && pready && csr_sel_phase) begin
         phase_ticks_ff <= pwdata[15:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_sel_phase) begin
         prdata[15:0] = phase_ticks_ff;
      end
   end

   // ---------------------------------------------------------------------
   // handshake: output register parts the two sides
   // ---------------------------------------------------------------------
   logic rsp_valid_ff;
   logic req_take;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // sequencer state
   // ---------------------------------------------------------------------
   logic [2:0]  op_ff,    op_in;
   logic [4:0]  phase_ff, phase_in;
   logic [15:0] tick_ff,  tick_in;
   logic [7:0]  shift_ff, shift_in;
   logic        scl_ff,   scl_in;
   logic        sda_ff,   sda_in;
   logic        ack_ff,   ack_in;
   logic        drive_ack_ff, drive_ack_in;
   logic [7:0]  rx_hold_ff,   rx_hold_in;
   logic        done_in;

   logic [15:0] limit;
   logic [15:0] tick_inc;
   logic [4:0]  phase_inc;

   assign limit     = (phase_ticks_ff == 16'd0) ? 16'd1 : phase_ticks_ff;
   assign tick_inc  = tick_ff + 16'd1;
   assign phase_inc = phase_ff + 5'd1;

   always_comb begin
      op_in        = op_ff;
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      shift_in     = shift_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      ack_in       = ack_ff;
      drive_ack_in = drive_ack_ff;
      rx_hold_in   = rx_hold_ff;
      done_in      = 1'b0;

      if (op_ff == i2cmbe_pkg::OP_IDLE) begin
         // launch a command and enter its first phase on this tick
         unique case (req_func)
            i2cmbe_pkg::OP_START: begin
               op_in    = req_func;
               phase_in = 5'd0;
               tick_in  = 16'd0;
               scl_in   = 1'b1;
            end
            i2cmbe_pkg::OP_STOP: begin
               op_in    = req_func;
               phase_in = 5'd0;
               tick_in  = 16'd0;
               sda_in   = 1'b0;
            end
            i2cmbe_pkg::OP_WRITE: begin
               op_in    = req_func;
               phase_in = 5'd0;
               tick_in  = 16'd0;
               shift_in = req_tx_byte;
               sda_in   = req_tx_byte[7];
            end
            i2cmbe_pkg::OP_READ: begin
               op_in    = req_func;
               phase_in = 5'd0;
               tick_in  = 16'd0;
               shift_in = 8'd0;
               sda_in   = 1'b1;
            end
            i2cmbe_pkg::OP_ACK: begin
               op_in        = req_func;
               phase_in     = 5'd0;
               tick_in      = 16'd0;
               drive_ack_in = req_ack_level;
               sda_in       = req_ack_level;
            end
            default: begin
               // no command
            end
         endcase
      end else begin
         tick_in = tick_inc;
         if (tick_inc >= limit) begin
            tick_in = 16'd0;

            // end of the current phase: scl-high phases sample or shift
            if (op_ff == i2cmbe_pkg::OP_WRITE && phase_ff[0]) begin
               scl_in   = 1'b0;
               shift_in = {shift_ff[6:0], 1'b0};
            end else if (op_ff == i2cmbe_pkg::OP_READ && phase_ff[0]) begin
               shift_in = {shift_ff[6:0], req_sda_in};
            end else if (op_ff == i2cmbe_pkg::OP_ACK && phase_ff == 5'd1) begin
               ack_in = req_sda_in;
            end

            if (phase_inc >= i2cmbe_pkg::phase_total(op_ff)) begin
               if (op_ff == i2cmbe_pkg::OP_READ) begin
                  rx_hold_in = shift_in;
               end
               op_in    = i2cmbe_pkg::OP_IDLE;
               phase_in = 5'd0;
               done_in  = 1'b1;
            end else begin
               phase_in = phase_inc;
               // enter the next phase
               unique case (op_ff)
                  i2cmbe_pkg::OP_START: begin
                     if (phase_inc == 5'd1) begin
                        sda_in = 1'b0;
                     end else begin
                        scl_in = 1'b0;
                     end
                  end
                  i2cmbe_pkg::OP_STOP: begin
                     if (phase_inc == 5'd1) begin
                        scl_in = 1'b1;
                     end else begin
                        sda_in = 1'b1;
                     end
                  end
                  i2cmbe_pkg::OP_WRITE: begin
                     if (!phase_inc[0]) begin
                        sda_in = shift_in[7];
                     end else begin
                        scl_in = 1'b1;
                     end
                  end
                  i2cmbe_pkg::OP_READ: begin
                     scl_in = phase_inc[0];
                  end
                  i2cmbe_pkg::OP_ACK: begin
                     scl_in = (phase_inc == 5'd1);
                  end
                  default: begin
                     // idle never reaches here
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= i2cmbe_pkg::OP_IDLE;
         phase_ff     <= 5'd0;
         tick_ff      <= 16'd0;
         shift_ff     <= 8'd0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ack_ff       <= 1'b0;
         drive_ack_ff <= 1'b1;
         rx_hold_ff   <= 8'd0;
      end else if (req_take) begin
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         shift_ff     <= shift_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         ack_ff       <= ack_in;
         drive_ack_ff <= drive_ack_in;
         rx_hold_ff   <= rx_hold_in;
      end
   end

   // ---------------------------------------------------------------------
   // response register, loaded with the post-tick view
   // ---------------------------------------------------------------------
   logic       rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff, rsp_ack_ff;
   logic [7:0] rsp_rx_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_scl_ff  <= scl_in;
         rsp_sda_ff  <= sda_in;
         rsp_busy_ff <= (op_in != i2cmbe_pkg::OP_IDLE);
         rsp_done_ff <= done_in;
         rsp_rx_ff   <= rx_hold_in;
         rsp_ack_ff  <= ack_in;
      end
   end

   assign rsp_scl_out     = rsp_scl_ff;
   assign rsp_sda_out     = rsp_sda_ff;
   assign rsp_busy_res    = rsp_busy_ff;
   assign rsp_done_res    = rsp_done_ff;
   assign rsp_rx_byte     = rsp_rx_ff;
   assign rsp_ack_sampled = rsp_ack_ff;

endmodule

// File: test/tb_i2c_master_bit_engine_top.sv
`timescale 1ns / 1ps

// self-checking bench for the i2c master bit engine: every tick request is run
// through a local line sequencer model and the response stream is compared
module tb_i2c_master_bit_engine_top;

   // run limits
   localparam int CYCLE_LIMIT   = 50_000;
   localparam int RANDOM_TICKS  = 90;
   localparam int PRESSURE_TICKS = 50;
   localparam int MAX_REPORTS   = 10;
   localparam logic [i2cmbe_pkg::CSR_ADDR_W-1:0] PHASE_TICKS_ADDR =
      {i2cmbe_pkg::REG_PHASE_TICKS, 2'b00};

   // how sda_in behaves while a command runs
   typedef enum {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_mode_type;

   // one line-state response
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rx;
      logic       ack;
   } line_resp_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic [2:0] req_func      = i2cmbe_pkg::OP_IDLE;
   logic [7:0] req_tx_byte   = 8'd0;
   logic       req_ack_level = 1'b0;
   logic       req_sda_in    = 1'b1;

   // response side
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_scl_out;
   logic       rsp_sda_out;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [7:0] rsp_rx_byte;
   logic       rsp_ack_sampled;

   // apb side, idle from time zero
   logic                                 psel    = 1'b0;
   logic                                 penable = 1'b0;
   logic                                 pwrite  = 1'b0;
   logic [i2cmbe_pkg::CSR_ADDR_W-1:0]    paddr   = '0;
   logic [i2cmbe_pkg::CSR_DATA_W-1:0]    pwdata  = '0;
   logic [i2cmbe_pkg::CSR_DATA_W-1:0]    prdata;
   logic                                 pready;

   // model of the sequencer, advanced once per accepted request
   logic [15:0] cfg_phase_ticks = i2cmbe_pkg::PHASE_TICKS_RESET;
   logic [2:0]  eng_op          = i2cmbe_pkg::OP_IDLE;
   logic [4:0]  eng_phase       = 5'd0;
   logic [15:0] eng_ticks       = 16'd0;
   logic [7:0]  eng_shift       = 8'd0;
   logic        eng_scl         = 1'b1;
   logic        eng_sda         = 1'b1;
   logic        eng_ack         = 1'b0;
   logic        eng_drive_ack   = 1'b1;
   logic [7:0]  eng_rx_hold     = 8'd0;

   // responses still owed by the dut, oldest first
   line_resp_type expected_lines[$];

   // bookkeeping
   int  ticks_sent     = 0;
   int  lines_checked  = 0;
   int  cmds_launched  = 0;
   int  mismatches     = 0;
   int  cycle_count    = 0;
   int  hold_left      = 0;
   bit  gaps_on        = 1'b1;

   i2c_master_bit_engine_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_tx_byte     (req_tx_byte),
      .req_ack_level   (req_ack_level),
      .req_sda_in      (req_sda_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_scl_out     (rsp_scl_out),
      .rsp_sda_out     (rsp_sda_out),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_rx_byte     (rsp_rx_byte),
      .rsp_ack_sampled (rsp_ack_sampled),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sized random values
   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [2:0] rand_func();
      return 3'($urandom_range(0, 7));
   endfunction

   // line changes made when a phase is entered
   function automatic void enter_phase();
      unique case (eng_op)
         i2cmbe_pkg::OP_START: begin
            if (eng_phase == 5'd0) eng_scl = 1'b1;
            else if (eng_phase == 5'd1) eng_sda = 1'b0;
            else eng_scl = 1'b0;
         end
         i2cmbe_pkg::OP_STOP: begin
            if (eng_phase == 5'd0) eng_sda = 1'b0;
            else if (eng_phase == 5'd1) eng_scl = 1'b1;
            else eng_sda = 1'b1;
         end
         i2cmbe_pkg::OP_WRITE: begin
            // even phases put the next bit on sda, odd phases raise scl
            if (!eng_phase[0]) eng_sda = eng_shift[7];
            else eng_scl = 1'b1;
         end
         i2cmbe_pkg::OP_READ: begin
            // release sda first, then scl high/low per bit
            if (eng_phase == 5'd0) eng_sda = 1'b1;
            else if (eng_phase[0]) eng_scl = 1'b1;
            else eng_scl = 1'b0;
         end
         i2cmbe_pkg::OP_ACK: begin
            if (eng_phase == 5'd0) eng_sda = eng_drive_ack;
            else if (eng_phase == 5'd1) eng_scl = 1'b1;
            else eng_scl = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // advance the model by one base tick and return the line state it shows
   function automatic line_resp_type tick_engine(input logic [2:0] func,
                                                 input logic [7:0] txb,
                                                 input logic ackl,
                                                 input logic sda);
      line_resp_type r;
      logic [15:0]   lim;
      logic [4:0]    last_phase;
      r.done = 1'b0;
      // a zero setting behaves as one tick per phase
      lim = (cfg_phase_ticks == 16'd0) ? 16'd1 : cfg_phase_ticks;
      if (eng_op == i2cmbe_pkg::OP_IDLE) begin
         // only a known command launches; unused codes leave it idle
         if (func >= i2cmbe_pkg::OP_START && func <= i2cmbe_pkg::OP_ACK) begin
            eng_op    = func;
            eng_phase = 5'd0;
            eng_ticks = 16'd0;
            if (func == i2cmbe_pkg::OP_WRITE) eng_shift = txb;
            else if (func == i2cmbe_pkg::OP_READ) eng_shift = 8'd0;
            else if (func == i2cmbe_pkg::OP_ACK) eng_drive_ack = ackl;
            cmds_launched++;
            enter_phase();
         end
      end else begin
         // busy: func is ignored, including on the finishing tick
         eng_ticks = eng_ticks + 16'd1;
         if (eng_ticks >= lim) begin
            eng_ticks = 16'd0;
            // end-of-phase actions: shift out, sample in, sample ack
            if (eng_op == i2cmbe_pkg::OP_WRITE && eng_phase[0]) begin
               eng_scl   = 1'b0;
               eng_shift = {eng_shift[6:0], 1'b0};
            end else if (eng_op == i2cmbe_pkg::OP_READ && eng_phase[0]) begin
               eng_shift = {eng_shift[6:0], sda};
            end else if (eng_op == i2cmbe_pkg::OP_ACK && eng_phase == 5'd1) begin
               eng_ack = sda;
            end
            unique case (eng_op)
               i2cmbe_pkg::OP_WRITE: last_phase = 5'd16;
               i2cmbe_pkg::OP_READ:  last_phase = 5'd17;
               default:              last_phase = 5'd3;
            endcase
            eng_phase = eng_phase + 5'd1;
            if (eng_phase >= last_phase) begin
               if (eng_op == i2cmbe_pkg::OP_READ) eng_rx_hold = eng_shift;
               eng_op    = i2cmbe_pkg::OP_IDLE;
               eng_phase = 5'd0;
               r.done    = 1'b1;
            end else begin
               enter_phase();
            end
         end
      end
      r.scl  = eng_scl;
      r.sda  = eng_sda;
      r.busy = (eng_op != i2cmbe_pkg::OP_IDLE);
      r.rx   = eng_rx_hold;
      r.ack  = eng_ack;
      return r;
   endfunction

   // offer one tick request, hold it until taken, then record its response
   task automatic send_tick(input logic [2:0] func, input logic [7:0] txb,
                            input logic ackl, input logic sda);
      // random bubbles before the request
      while (gaps_on && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_tx_byte   <= txb;
      req_ack_level <= ackl;
      req_sda_in    <= sda;
      do @(posedge clock); while (!req_ready);
      // accepted at this edge: model moves in the same process
      expected_lines.push_back(tick_engine(func, txb, ackl, sda));
      ticks_sent++;
   endtask

   // keep ticking until the running command has finished
   task automatic finish_command(input sda_mode_type mode);
      logic [2:0] f;
      logic       s;
      while (eng_op != i2cmbe_pkg::OP_IDLE) begin
         // mostly empty ticks, some stray commands that must be ignored
         if ($urandom_range(0, 4) == 0) f = rand_func();
         else f = i2cmbe_pkg::OP_IDLE;
         unique case (mode)
            SDA_LOW:  s = 1'b0;
            SDA_HIGH: s = 1'b1;
            default:  s = rand_bit();
         endcase
         send_tick(f, rand_byte(), rand_bit(), s);
      end
   endtask

   // launch one command from idle and run it to completion
   task automatic issue_cmd(input logic [2:0] func, input logic [7:0] txb,
                            input logic ackl, input sda_mode_type mode);
      send_tick(func, txb, ackl, rand_bit());
      finish_command(mode);
   endtask

   // stop offering and wait until every owed response has come back
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
   endtask

   // apb write of phase_ticks, only from an idle engine
   task automatic write_phase_ticks(input logic [15:0] value);
      settle_idle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PHASE_TICKS_ADDR;
      pwdata  <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cfg_phase_ticks = value;
   endtask

   // one bus transaction, mostly well formed, sometimes noise or no stop
   task automatic random_transfer();
      int nbytes;
      if ($urandom_range(0, 9) == 0) begin
         issue_cmd(rand_func(), rand_byte(), rand_bit(), SDA_RANDOM);
      end else begin
         nbytes = $urandom_range(1, 3);
         issue_cmd(i2cmbe_pkg::OP_START, rand_byte(), 1'b1, SDA_RANDOM);
         repeat (nbytes) begin
            if ($urandom_range(0, 2) != 0)
               issue_cmd(i2cmbe_pkg::OP_WRITE, rand_byte(), 1'b1, SDA_RANDOM);
            else
               issue_cmd(i2cmbe_pkg::OP_READ, rand_byte(), 1'b1, SDA_RANDOM);
            issue_cmd(i2cmbe_pkg::OP_ACK, rand_byte(), rand_bit(), SDA_RANDOM);
         end
         if ($urandom_range(0, 9) != 0)
            issue_cmd(i2cmbe_pkg::OP_STOP, rand_byte(), 1'b1, SDA_RANDOM);
      end
   endtask

   // out of reset: default of 100 ticks per phase
   task automatic test_default_timing();
      issue_cmd(i2cmbe_pkg::OP_START, 8'h00, 1'b1, SDA_RANDOM);
   endtask

   // each command, byte extremes, ack levels, unused codes, busy commands
   task automatic test_command_edges();
      write_phase_ticks(16'd1);
      issue_cmd(i2cmbe_pkg::OP_START, 8'h00, 1'b0, SDA_RANDOM);
      issue_cmd(i2cmbe_pkg::OP_WRITE, 8'h00, 1'b1, SDA_LOW);
      issue_cmd(i2cmbe_pkg::OP_ACK, 8'h00, 1'b0, SDA_LOW);
      issue_cmd(i2cmbe_pkg::OP_WRITE, 8'hFF, 1'b0, SDA_HIGH);
      issue_cmd(i2cmbe_pkg::OP_ACK, 8'hFF, 1'b1, SDA_HIGH);
      issue_cmd(i2cmbe_pkg::OP_WRITE, 8'hA5, 1'b1, SDA_RANDOM);
      issue_cmd(i2cmbe_pkg::OP_READ, 8'hFF, 1'b1, SDA_LOW);
      issue_cmd(i2cmbe_pkg::OP_READ, 8'h00, 1'b0, SDA_HIGH);
      issue_cmd(i2cmbe_pkg::OP_READ, 8'h5A, 1'b1, SDA_RANDOM);
      issue_cmd(i2cmbe_pkg::OP_ACK, 8'h00, 1'b1, SDA_RANDOM);
      // unused codes from idle do nothing
      issue_cmd(3'd6, 8'hFF, 1'b1, SDA_RANDOM);
      issue_cmd(3'd7, 8'h00, 1'b0, SDA_RANDOM);
      issue_cmd(i2cmbe_pkg::OP_IDLE, 8'hFF, 1'b1, SDA_RANDOM);
      // a start on every busy tick of a stop, done tick included
      send_tick(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0, 1'b1);
      while (eng_op != i2cmbe_pkg::OP_IDLE)
         send_tick(i2cmbe_pkg::OP_START, 8'hFF, 1'b1, 1'b1);
      // a write right after a start is launched must be dropped
      send_tick(i2cmbe_pkg::OP_START, 8'h00, 1'b1, 1'b1);
      send_tick(i2cmbe_pkg::OP_WRITE, 8'hC3, 1'b0, 1'b0);
      finish_command(SDA_RANDOM);
   endtask

   // zero ticks per phase acts as one
   task automatic test_zero_phase_ticks();
      write_phase_ticks(16'd0);
      issue_cmd(i2cmbe_pkg::OP_START, 8'h00, 1'b1, SDA_RANDOM);
      issue_cmd(i2cmbe_pkg::OP_WRITE, rand_byte(), 1'b1, SDA_RANDOM);
      issue_cmd(i2cmbe_pkg::OP_ACK, 8'h00, 1'b0, SDA_RANDOM);
      issue_cmd(i2cmbe_pkg::OP_READ, 8'h00, 1'b1, SDA_RANDOM);
      issue_cmd(i2cmbe_pkg::OP_STOP, 8'h00, 1'b1, SDA_RANDOM);
   endtask

   // response side held off while requests keep coming, so the dut backs up
   task automatic test_output_backpressure();
      int first;
      write_phase_ticks(16'd1);
      gaps_on = 1'b0;
      hold_left <= 150;
      first = ticks_sent;
      while (ticks_sent - first < PRESSURE_TICKS) random_transfer();
      gaps_on = 1'b1;
   endtask

   // random transactions over phase settings of one and two ticks, one block without gaps
   task automatic test_random_transfers();
      int          first;
      logic [15:0] p;
      first = ticks_sent;
      for (int blk = 0; blk < 3; blk++) begin
         p = (blk == 2) ? 16'd2 : 16'd1;
         write_phase_ticks(p);
         gaps_on = (blk != 1);
         while (ticks_sent - first < (RANDOM_TICKS / 3) * (blk + 1))
            random_transfer();
      end
      gaps_on = 1'b1;
   endtask

   // largest phase length: a start holds its first phase, stray commands ignored
   task automatic test_longest_phase();
      write_phase_ticks(16'hFFFF);
      send_tick(i2cmbe_pkg::OP_START, rand_byte(), 1'b1, rand_bit());
      repeat (20) send_tick(rand_func(), rand_byte(), rand_bit(), rand_bit());
   endtask

   // response sink: random stalls, plus a counted hold-off when requested
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (gaps_on && $urandom_range(0, 99) < 9) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each response against the oldest expectation
   always @(posedge clock) begin
      line_resp_type want;
      line_resp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_scl_out, rsp_sda_out, rsp_busy_res, rsp_done_res,
                 rsp_rx_byte, rsp_ack_sampled};
         if (expected_lines.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                        got.scl, got.sda, got.busy, got.done, got.rx, got.ack);
         end else begin
            want = expected_lines.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("response %0d mismatch", lines_checked);
                  $display("  expected scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                           want.scl, want.sda, want.busy, want.done, want.rx, want.ack);
                  $display("  actual   scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                           got.scl, got.sda, got.busy, got.done, got.rx, got.ack);
               end
            end
            lines_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // test sequence
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_default_timing();
      test_command_edges();
      test_zero_phase_ticks();
      test_output_backpressure();
      test_random_transfers();
      test_longest_phase();
      settle_idle();
      // let any stray response arrive before the final count
      repeat (8) @(posedge clock);
      mismatches += expected_lines.size();
      $display("ran %0d tick requests, %0d responses checked, %0d commands launched",
               ticks_sent, lines_checked, cmds_launched);
      $display("covered reset timing, 1/0/2 ticks per phase, max phase, long output stall");
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/i2cmbe_pkg.sv
sv/i2c_master_bit_engine_top.sv
test/tb_i2c_master_bit_engine_top.sv
